/* rtl/core/assert_macros.svh */
// assert_macros.svh - shared concurrent assertion shorthands
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* rtl/core/nva_pkg.sv */
// ----------------------------------------------------------------------------
// nva_pkg
// Shared codes and types for the note voice allocator.
// ----------------------------------------------------------------------------
package nva_pkg;

   localparam int NOTE_W     = 7;
   localparam int MODE_W     = 2;
   localparam int SLOTCFG_W  = 4;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RR     = 2'd2;

   localparam logic FUNC_ASSIGN = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CHAIN_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 2'd1;

   typedef struct packed {
      logic              busy;
      logic [NOTE_W-1:0] note;
   } entry_type;

endpackage

/* rtl/core/note_voice_allocator_top.sv */
// ----------------------------------------------------------------------------
// note_voice_allocator_top
// Polyphonic voice allocator: note-on takes free slots, note-off frees them.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one note event (req_func, req_note).
// Slot state (busy flag and note) lives in a one-port-read synchronous RAM that
// is scanned one slot per cycle; an event visits up to n slots from accept to
// the response strobe, n being the active slot count (fewer when first-available
// or round-robin stops early; none when nothing is searched). Busy drops
// in the cycle the response is shown, so the next event can be accepted then.
// The response is on rsp_* for exactly one cycle with rsp_valid high and must
// be captured then; the receiver cannot stall the block. Config writes are
// always accepted (csr_ready is tied high) and must only occur while idle.
// ----------------------------------------------------------------------------
module note_voice_allocator_top
   import nva_pkg::*;
#(
   parameter int NUM_SLOTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [NOTE_W-1:0]     req_note,
   output logic                  rsp_valid,
   output logic                  rsp_success,
   output logic [MASK_W-1:0]     rsp_slot_mask,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // slot RAM, entries read as free/zero until first written
   entry_type              slot_mem [NUM_SLOTS];
   entry_type              rd_ff;
   logic [NUM_SLOTS-1:0]   written_ff, written_in;

   logic                   state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [SLOTCFG_W-1:0]   slots_ff, slots_in;
   logic [SW-1:0]          last_slot_ff, last_slot_in;
   logic                   last_valid_ff, last_valid_in;

   logic                   func_ff, func_in;
   logic [NOTE_W-1:0]      note_ff, note_in;
   logic [CW-1:0]          n_ff, n_in;
   logic                   down_ff, down_in;
   logic [SW-1:0]          addr_ff, addr_in;
   logic [CW-1:0]          left_ff, left_in;
   logic                   pend_ff, pend_in;
   logic [SW-1:0]          eval_ff, eval_in;
   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic                   succ_ff, succ_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_success_ff, rsp_success_in;
   logic [MASK_W-1:0]      rsp_mask_ff, rsp_mask_in;

   logic [CW-1:0]          n_cur;
   logic [CW-1:0]          rr_next;
   logic [SW-1:0]          start_slot;
   logic [CW-1:0]          start_left;
   logic                   accept;
   entry_type              ent;
   entry_type              wr_entry;
   logic                   hit;
   logic                   stop_now;
   logic                   issue;
   logic                   done_now;
   logic [CW-1:0]          addr_up;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // active slot count, clamped to 1..NUM_SLOTS
   always_comb begin
      if (slots_ff == '0) begin
         n_cur = CW'(1);
      end else if (32'(slots_ff) > NUM_SLOTS) begin
         n_cur = CW'(NUM_SLOTS);
      end else begin
         n_cur = CW'(slots_ff);
      end
   end

   // first slot searched and number of slots to visit
   always_comb begin
      rr_next    = last_valid_ff ? CW'(last_slot_ff) + CW'(1) : '0;
      start_slot = '0;
      start_left = n_cur;
      down_in    = 1'b0;
      if (mode_ff == MODE_RR) begin
         if (req_func == FUNC_ASSIGN) begin
            start_slot = (rr_next >= n_cur) ? '0 : SW'(rr_next);
         end else begin
            down_in = 1'b1;
            if (!last_valid_ff) begin
               start_left = '0;
            end
            if (last_slot_ff == '0 || CW'(last_slot_ff) >= n_cur) begin
               start_slot = SW'(n_cur - CW'(1));
            end else begin
               start_slot = last_slot_ff - SW'(1);
            end
         end
      end else if (mode_ff != MODE_DIRECT && mode_ff != MODE_FIRST) begin
         start_left = '0;
      end
   end

   // evaluate the slot read last cycle
   always_comb begin
      ent = written_ff[eval_ff] ? rd_ff : '0;
      if (func_ff == FUNC_CLEAR) begin
         hit      = pend_ff && ent.busy && (ent.note == note_ff);
         wr_entry = '{busy: 1'b0, note: ent.note};
      end else begin
         hit      = pend_ff && !ent.busy;
         wr_entry = '{busy: 1'b1, note: note_ff};
      end
      stop_now = hit && (mode_ff != MODE_DIRECT);
      issue    = (left_ff != '0) && !stop_now;
      done_now = stop_now || (left_ff == '0);
      addr_up  = CW'(addr_ff) + CW'(1);
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      slots_in       = slots_ff;
      last_slot_in   = last_slot_ff;
      last_valid_in  = last_valid_ff;
      written_in     = written_ff;
      func_in        = func_ff;
      note_in        = note_ff;
      n_in           = n_ff;
      addr_in        = addr_ff;
      left_in        = left_ff;
      pend_in        = 1'b0;
      eval_in        = eval_ff;
      mask_in        = mask_ff;
      succ_in        = succ_ff;
      rsp_valid_in   = 1'b0;
      rsp_success_in = rsp_success_ff;
      rsp_mask_in    = rsp_mask_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CHAIN_MODE:   mode_in  = csr_data[MODE_W-1:0];
            CSR_SLOTS_IN_USE: slots_in = csr_data[SLOTCFG_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               note_in  = req_note;
               n_in     = n_cur;
               addr_in  = start_slot;
               left_in  = start_left;
               mask_in  = '0;
               succ_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               written_in[eval_ff] = 1'b1;
               mask_in             = mask_ff | (MASK_W'(1) << eval_ff);
               succ_in             = 1'b1;
               if (mode_ff == MODE_RR && func_ff == FUNC_ASSIGN) begin
                  last_slot_in  = eval_ff;
                  last_valid_in = 1'b1;
               end
            end
            if (issue) begin
               pend_in = 1'b1;
               eval_in = addr_ff;
               left_in = left_ff - CW'(1);
               if (down_ff) begin
                  addr_in = (addr_ff == '0) ? SW'(n_ff - CW'(1)) : addr_ff - SW'(1);
               end else begin
                  addr_in = (addr_up >= n_ff) ? '0 : SW'(addr_up);
               end
            end
            if (done_now) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = succ_in;
               rsp_mask_in    = mask_in;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // slot RAM: one read, one write per cycle; slots differ within an event
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && hit) begin
         slot_mem[eval_ff] <= wr_entry;
      end
      rd_ff <= slot_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_DIRECT;
         slots_ff      <= SLOTCFG_W'(1);
         last_slot_ff  <= '0;
         last_valid_ff <= 1'b0;
         written_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         slots_ff      <= slots_in;
         last_slot_ff  <= last_slot_in;
         last_valid_ff <= last_valid_in;
         written_ff    <= written_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      note_ff        <= note_in;
      n_ff           <= n_in;
      down_ff        <= (state_ff == ST_IDLE) ? down_in : down_ff;
      addr_ff        <= addr_in;
      left_ff        <= left_in;
      eval_ff        <= eval_in;
      mask_ff        <= mask_in;
      succ_ff        <= succ_in;
      rsp_success_ff <= rsp_success_in;
      rsp_mask_ff    <= rsp_mask_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_success   = rsp_success_ff;
   assign rsp_slot_mask = rsp_mask_ff;

endmodule

/* rtl/core/nva_checker.sv */
// ----------------------------------------------------------------------------
// nva_checker
// Port-level checks on the note voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nva_checker
   import nva_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic                  rsp_success,
   input logic [MASK_W-1:0]     rsp_slot_mask
);

   // an accepted event raises busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // a response only ends a busy stretch
   `ASSERT_IMPLY(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy) && !busy)

   // one response per event
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)

   // any shown slot change means success
   `ASSERT_IMPLY(a_mask_success, clock, reset, rsp_valid && (rsp_slot_mask != '0), rsp_success)

endmodule

bind note_voice_allocator_top nva_checker u_nva_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_success   (rsp_success),
   .rsp_slot_mask (rsp_slot_mask)
);
